### sv/pll_pkg.sv
// Package for the positional list: sizes, codes and request/response types.
`default_nettype none

package pll_pkg;

  localparam int CAPACITY = 32;
  localparam int DATA_W   = 32;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    KIND_TRAVERSE = 2'd0,
    KIND_INSERT   = 2'd1,
    KIND_DELETE   = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_BADPOS = 2'd1,
    STAT_FULL   = 2'd2,
    STAT_EMPTY  = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]               kind;
    logic [5:0]               position;
    logic signed [DATA_W-1:0] new_value;
  } req_t;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [DATA_W-1:0] element_value;
    logic [4:0]               element_index;
    logic                     last;
  } rsp_t;

endpackage

`default_nettype wire

### sv/pll_ram.sv
// Generic simple dual-port RAM with registered read data.
`default_nettype none

module pll_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### sv/positional_list_insert_delete.sv
// Positional list: top level with sequencer, list memory and response register.
`default_nettype none

// Ordered list of up to CAPACITY signed 32-bit values held in one simple
// dual-port RAM (one write port, one registered read port). A request is
// taken only while the sequencer is idle and the response register can take
// a new response. Insert and delete post their single status response at
// once and then move the later entries one slot at a time through the RAM:
// an insert at position p into a list of n entries shifts entries p to n-1
// up by one, top entry first, then writes the new value at p; a delete
// shifts entries p+1 to n-1 down by one, bottom entry first. Moving one
// entry per cycle is set by the single RAM read port. A traverse streams
// one entry per cycle out of the RAM while the response side does not
// stall; an empty list gives one empty status response. Error responses
// (bad position, full) and the empty traverse leave the sequencer idle.
// Request kind 3 is dropped without a response. No clearing pass after
// reset: only entries below the count are ever read.
module positional_list_insert_delete
  import pll_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire req_t req,
  input  wire logic req_valid,
  output logic      req_stall,
  output rsp_t      rsp,
  output logic      rsp_valid,
  input  wire logic rsp_stall
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SHIFT = 3'b010,
    ST_TRAV  = 3'b100
  } state_t;

  state_t state, state_next;

  logic [CNT_W-1:0]  count, count_next;       // valid entries
  logic [IDX_W-1:0]  cursor, cursor_next;     // traverse emit index
  logic [IDX_W-1:0]  rd_ptr, rd_ptr_next;
  logic [IDX_W-1:0]  wr_ptr, wr_ptr_next;
  logic [CNT_W-1:0]  rd_left, rd_left_next;   // RAM reads still to issue
  logic              pend, pend_next;         // RAM read data is live
  logic              is_ins, is_ins_next;
  logic [IDX_W-1:0]  ins_pos, ins_pos_next;
  logic [DATA_W-1:0] ins_val, ins_val_next;
  logic              rsp_valid_next;

  logic              load;
  rsp_t              load_data;

  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic              ram_re;
  logic [IDX_W-1:0]  ram_raddr;
  logic [DATA_W-1:0] ram_rdata;

  logic              slot_free;
  logic              accept;
  logic [31:0]       pos_ext;
  logic [31:0]       cnt_ext;
  logic              trav_last;

  pll_ram #(
    .WIDTH(DATA_W),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // response register frees up this cycle if empty or being taken
  assign slot_free = !rsp_valid || !rsp_stall;
  assign req_stall = !((state == ST_IDLE) && slot_free);
  assign accept    = req_valid && !req_stall;
  assign pos_ext   = 32'(req.position);
  assign cnt_ext   = 32'(count);
  assign trav_last = ((32'(cursor) + 32'd1) == cnt_ext);

  always_comb begin
    state_next     = state;
    count_next     = count;
    cursor_next    = cursor;
    rd_ptr_next    = rd_ptr;
    wr_ptr_next    = wr_ptr;
    rd_left_next   = rd_left;
    pend_next      = pend;
    is_ins_next    = is_ins;
    ins_pos_next   = ins_pos;
    ins_val_next   = ins_val;
    rsp_valid_next = rsp_valid && rsp_stall;
    load           = 1'b0;
    load_data      = '0;
    ram_we         = 1'b0;
    ram_waddr      = wr_ptr;
    ram_wdata      = ram_rdata;
    ram_re         = 1'b0;
    ram_raddr      = rd_ptr;

    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (req.kind)
            KIND_TRAVERSE: begin
              if (count == '0) begin
                load             = 1'b1;
                load_data.status = STAT_EMPTY;
                load_data.last   = 1'b1;
              end else begin
                state_next   = ST_TRAV;
                rd_ptr_next  = '0;
                rd_left_next = count;
                pend_next    = 1'b0;
                cursor_next  = '0;
              end
            end
            KIND_INSERT: begin
              load           = 1'b1;
              load_data.last = 1'b1;
              if (pos_ext > cnt_ext) begin
                load_data.status = STAT_BADPOS;
              end else if (cnt_ext >= 32'(CAPACITY)) begin
                load_data.status = STAT_FULL;
              end else begin
                // shift [pos, n-1] up by one, top entry first
                load_data.status = STAT_OK;
                count_next       = CNT_W'(cnt_ext + 32'd1);
                state_next       = ST_SHIFT;
                is_ins_next      = 1'b1;
                rd_ptr_next      = IDX_W'(cnt_ext - 32'd1);
                wr_ptr_next      = IDX_W'(cnt_ext);
                rd_left_next     = CNT_W'(cnt_ext - pos_ext);
                ins_pos_next     = IDX_W'(req.position);
                ins_val_next     = req.new_value;
                pend_next        = 1'b0;
              end
            end
            KIND_DELETE: begin
              load           = 1'b1;
              load_data.last = 1'b1;
              if (pos_ext >= cnt_ext) begin
                load_data.status = STAT_BADPOS;
              end else begin
                // shift [pos+1, n-1] down by one, bottom entry first
                load_data.status = STAT_OK;
                count_next       = CNT_W'(cnt_ext - 32'd1);
                state_next       = ST_SHIFT;
                is_ins_next      = 1'b0;
                rd_ptr_next      = IDX_W'(pos_ext + 32'd1);
                wr_ptr_next      = IDX_W'(pos_ext);
                rd_left_next     = CNT_W'(cnt_ext - pos_ext - 32'd1);
                pend_next        = 1'b0;
              end
            end
            default: begin
            end
          endcase
        end
      end

      ST_SHIFT: begin
        // write side trails the read side by two slots, so they never meet
        if (pend) begin
          ram_we      = 1'b1;
          ram_waddr   = wr_ptr;
          ram_wdata   = ram_rdata;
          wr_ptr_next = is_ins ? wr_ptr - 1'b1 : wr_ptr + 1'b1;
        end
        if (rd_left != '0) begin
          ram_re       = 1'b1;
          ram_raddr    = rd_ptr;
          rd_ptr_next  = is_ins ? rd_ptr - 1'b1 : rd_ptr + 1'b1;
          rd_left_next = rd_left - 1'b1;
          pend_next    = 1'b1;
        end else begin
          pend_next = 1'b0;
        end
        if (!pend && (rd_left == '0)) begin
          if (is_ins) begin
            ram_we    = 1'b1;
            ram_waddr = ins_pos;
            ram_wdata = ins_val;
          end
          state_next = ST_IDLE;
        end
      end

      ST_TRAV: begin
        if (pend && slot_free) begin
          load                    = 1'b1;
          load_data.status        = STAT_OK;
          load_data.element_value = ram_rdata;
          load_data.element_index = 5'(cursor);
          load_data.last          = trav_last;
          if (trav_last) begin
            cursor_next = '0;
            state_next  = ST_IDLE;
          end else begin
            cursor_next = cursor + 1'b1;
          end
        end
        // next read only once the held read data has a place to go
        if ((rd_left != '0) && (!pend || slot_free)) begin
          ram_re       = 1'b1;
          ram_raddr    = rd_ptr;
          rd_ptr_next  = rd_ptr + 1'b1;
          rd_left_next = rd_left - 1'b1;
          pend_next    = 1'b1;
        end else begin
          pend_next = pend && !slot_free;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase

    if (load) begin
      rsp_valid_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      cursor    <= '0;
      rd_left   <= '0;
      pend      <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      cursor    <= cursor_next;
      rd_left   <= rd_left_next;
      pend      <= pend_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    rd_ptr  <= rd_ptr_next;
    wr_ptr  <= wr_ptr_next;
    is_ins  <= is_ins_next;
    ins_pos <= ins_pos_next;
    ins_val <= ins_val_next;
    if (load) begin
      rsp <= load_data;
    end
  end

`ifndef SYNTH
  // a shift never writes the slot it reads in the same cycle
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (rst)
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("RAM read and write hit the same entry");

  // the last traverse response returns the sequencer to idle, cursor cleared
  a_trav_end: assert property (@(posedge clk) disable iff (rst)
    (state == ST_TRAV && load && trav_last) |=> (state == ST_IDLE && cursor == '0))
    else $error("traverse did not finish cleanly");

  // the count moves only right after an accepted request
  a_count_moves: assert property (@(posedge clk) disable iff (rst)
    (count != $past(count)) |-> $past(accept))
    else $error("entry count changed without a request");

  // count stays within capacity
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    accept |=> (32'(count) <= 32'(CAPACITY)))
    else $error("entry count above capacity");
`endif

endmodule

`default_nettype wire
